### hw/rtl/deadband_change_coalescer_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the deadband change coalescer
// Clocked implication checks, each with a reset guard.
// ------------------------------------------------------------------------
`ifndef DEADBAND_CHANGE_COALESCER_ASSERT_SVH
`define DEADBAND_CHANGE_COALESCER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define DCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coalescer check failed");
// Next-cycle implication.
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coalescer check failed");
`else
`define DCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/dcc_pkg.sv
// ------------------------------------------------------------------------
// dcc_pkg
// Types and constants shared by the deadband change coalescer.
// ------------------------------------------------------------------------
package dcc_pkg;

    localparam int DEF_PATH_SLOTS = 8;
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_VALUE_BITS = 32;

    localparam int IN_VALUE_W = 32;
    localparam int EPS_W      = 31;
    localparam int FIELD_W    = 3;

    typedef enum logic {
        CMD_POST = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                         command;
        logic [FIELD_W-1:0]           path_slot;
        logic [FIELD_W-1:0]           channel;
        logic signed [IN_VALUE_W-1:0] value;
        logic [EPS_W-1:0]             epsilon;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]           out_path_slot;
        logic [FIELD_W-1:0]           out_channel;
        logic signed [IN_VALUE_W-1:0] sent_value;
        logic                         last_of_run;
    } result_t;

    // Write controls for the slot table.
    typedef struct packed {
        logic post;    // store pending value and epsilon, raise pending flag
        logic retire;  // drop pending flag after the scan has judged the slot
        logic emit;    // with retire: record value as sent, raise sent-once flag
        logic wipe;    // clear both flags (reset pass)
    } table_wr_t;

endpackage

### hw/rtl/deadband_change_coalescer.sv
// ------------------------------------------------------------------------
// deadband_change_coalescer
// Report-by-exception coalescer: posts park values per slot, a tick
// flushes pending slots never sent or whose change leaves their deadband.
// ------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  -----------------
//  item      in         start & !busy          dcc_pkg::item_t
//  result    out        result_valid (strobe)  dcc_pkg::result_t
//
//  A post is written to the table as it is accepted. A tick scans every
//  slot in index order: a table read, a difference stage and a compare
//  stage in the shared deadband unit per slot, then a closing state.
//  After reset a clearing pass over all slots zeroes the flag
//  memories; busy stays high until it ends.
//  Results are strobed for one cycle each and cannot be held off; an
//  emission is held back until the next one or the end of the scan, so
//  that the final one can carry last_of_run.
//
module deadband_change_coalescer #(
    parameter int PATH_SLOTS = dcc_pkg::DEF_PATH_SLOTS,
    parameter int CHANNELS   = dcc_pkg::DEF_CHANNELS,
    parameter int VALUE_BITS = dcc_pkg::DEF_VALUE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dcc_pkg::item_t    item,
    output logic              busy,
    output dcc_pkg::result_t  result,
    output logic              result_valid
);

    `include "deadband_change_coalescer_assert.svh"

    localparam int SLOT_COUNT = PATH_SLOTS * CHANNELS;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW         = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;
    localparam int CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IN_BITS    = (VALUE_BITS > dcc_pkg::IN_VALUE_W) ?
                                dcc_pkg::IN_VALUE_W : VALUE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    // Emission waiting for its successor, without the last_of_run mark.
    typedef struct packed {
        logic [dcc_pkg::FIELD_W-1:0]           path;
        logic [dcc_pkg::FIELD_W-1:0]           chan;
        logic signed [dcc_pkg::IN_VALUE_W-1:0] value;
    } held_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PW-1:0]     path_reg, path_next;
    logic [CHW-1:0]    chan_reg, chan_next;
    held_t             hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;
    dcc_pkg::result_t  result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    dcc_pkg::table_wr_t            wr;
    logic [IDX_W-1:0]              wr_addr;
    logic [IDX_W-1:0]              post_idx;
    logic                          post_in_range;
    logic signed [VALUE_BITS-1:0]  post_value;
    logic signed [VALUE_BITS-1:0]  rd_value;
    logic signed [VALUE_BITS-1:0]  rd_last;
    logic [dcc_pkg::EPS_W-1:0]     rd_eps;
    logic                          rd_pend;
    logic                          rd_sent;
    logic                          exceed;
    logic                          accept;
    logic                          emit;
    logic                          last_slot;

    assign accept = start && (state_reg == ST_IDLE);

    // Slot index of a post; drop it when outside the table.
    assign post_in_range = (32'(item.path_slot) < PATH_SLOTS) &&
                           (32'(item.channel) < CHANNELS);
    assign post_idx      = IDX_W'(32'(item.path_slot) * CHANNELS + 32'(item.channel));
    assign post_value    = VALUE_BITS'($signed(item.value[IN_BITS-1:0]));

    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    // Send when never sent before, or when the change leaves the deadband.
    assign emit = rd_pend && (!rd_sent || exceed);

    always_comb
    begin
        wr         = '0;
        wr_addr    = idx_reg;
        if (state_reg == ST_IDLE)
        begin
            wr_addr = post_idx;
            wr.post = accept && (item.command == dcc_pkg::CMD_POST) && post_in_range;
        end
        else if (state_reg == ST_CLEAR)
        begin
            wr.wipe = 1'b1;
        end
        else if (state_reg == ST_DECIDE)
        begin
            wr.retire = 1'b1;
            wr.emit   = emit;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        path_next         = path_reg;
        chan_next         = chan_reg;
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (last_slot)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (item.command == dcc_pkg::CMD_TICK))
                begin
                    idx_next   = '0;
                    path_next  = '0;
                    chan_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (emit)
                begin
                    // Release the held emission, it is not the final one.
                    if (hold_valid_reg)
                    begin
                        result_next.out_path_slot = hold_reg.path;
                        result_next.out_channel   = hold_reg.chan;
                        result_next.sent_value    = hold_reg.value;
                        result_next.last_of_run   = 1'b0;
                        result_valid_next         = 1'b1;
                    end
                    hold_next.path  = dcc_pkg::FIELD_W'(path_reg);
                    hold_next.chan  = dcc_pkg::FIELD_W'(chan_reg);
                    hold_next.value = dcc_pkg::IN_VALUE_W'(rd_value);
                    hold_valid_next = 1'b1;
                end
                if (last_slot)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                    if (chan_reg == CHW'(CHANNELS - 1))
                    begin
                        chan_next = '0;
                        path_next = path_reg + 1'b1;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    result_next.out_path_slot = hold_reg.path;
                    result_next.out_channel   = hold_reg.chan;
                    result_next.sent_value    = hold_reg.value;
                    result_next.last_of_run   = 1'b1;
                    result_valid_next         = 1'b1;
                end
                hold_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            path_reg         <= '0;
            chan_reg         <= '0;
            hold_reg         <= '0;
            hold_valid_reg   <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            path_reg         <= path_next;
            chan_reg         <= chan_next;
            hold_reg         <= hold_next;
            hold_valid_reg   <= hold_valid_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    dcc_slot_table #(
        .SLOTS      (SLOT_COUNT),
        .IDX_W      (IDX_W),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .clk        (clk),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .post_value (post_value),
        .post_eps   (item.epsilon),
        .rd_addr    (idx_reg),
        .rd_value   (rd_value),
        .rd_last    (rd_last),
        .rd_eps     (rd_eps),
        .rd_pend    (rd_pend),
        .rd_sent    (rd_sent)
    );

    // Load the difference stage while the slot's table data is fresh.
    dcc_deadband_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .clk       (clk),
        .load      (state_reg == ST_DIFF),
        .pending   (rd_value),
        .last_sent (rd_last),
        .eps       (rd_eps),
        .exceed    (exceed)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // The final item of a tick appears once the scan has closed.
    `DCC_ASSERT_IMPLIES(a_last_when_idle, clk, rst_n,
        result_valid && result.last_of_run, state_reg == ST_IDLE)
    // Other items appear only while the scan is still running.
    `DCC_ASSERT_IMPLIES(a_mid_in_scan, clk, rst_n,
        result_valid && !result.last_of_run,
        (state_reg == ST_READ) || (state_reg == ST_FLUSH))
    // A tick holds intake off.
    `DCC_ASSERT_NEXT(a_tick_busy, clk, rst_n,
        accept && (item.command == dcc_pkg::CMD_TICK), busy)
    // Closing the scan leaves nothing held back.
    `DCC_ASSERT_NEXT(a_flush_empties, clk, rst_n,
        state_reg == ST_FLUSH, !hold_valid_reg)

endmodule

### hw/rtl/dcc_slot_table.sv
// ------------------------------------------------------------------------
// dcc_slot_table
// Slot memories: pending value, epsilon, last sent value and two flags.
// ------------------------------------------------------------------------
module dcc_slot_table #(
    parameter int SLOTS      = dcc_pkg::DEF_PATH_SLOTS * dcc_pkg::DEF_CHANNELS,
    parameter int IDX_W      = 6,
    parameter int VALUE_BITS = dcc_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  dcc_pkg::table_wr_t            wr,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic signed [VALUE_BITS-1:0]  post_value,
    input  logic [dcc_pkg::EPS_W-1:0]     post_eps,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic signed [VALUE_BITS-1:0]  rd_value,
    output logic signed [VALUE_BITS-1:0]  rd_last,
    output logic [dcc_pkg::EPS_W-1:0]     rd_eps,
    output logic                          rd_pend,
    output logic                          rd_sent
);

    logic signed [VALUE_BITS-1:0]  value_mem [SLOTS];
    logic signed [VALUE_BITS-1:0]  last_mem  [SLOTS];
    logic [dcc_pkg::EPS_W-1:0]     eps_mem   [SLOTS];
    logic                          pend_mem  [SLOTS];
    logic                          sent_mem  [SLOTS];

    logic signed [VALUE_BITS-1:0]  rd_value_reg;
    logic signed [VALUE_BITS-1:0]  rd_last_reg;
    logic [dcc_pkg::EPS_W-1:0]     rd_eps_reg;
    logic                          rd_pend_reg;
    logic                          rd_sent_reg;

    always_ff @(posedge clk)
    begin
        if (wr.post)
        begin
            value_mem[wr_addr] <= post_value;
            eps_mem[wr_addr]   <= post_eps;
        end
        rd_value_reg <= value_mem[rd_addr];
        rd_eps_reg   <= eps_mem[rd_addr];
    end

    // Copy the pending value read for this slot into the sent record.
    always_ff @(posedge clk)
    begin
        if (wr.retire && wr.emit)
        begin
            last_mem[wr_addr] <= rd_value_reg;
        end
        rd_last_reg <= last_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.post)
        begin
            pend_mem[wr_addr] <= 1'b1;
        end
        else if (wr.retire || wr.wipe)
        begin
            pend_mem[wr_addr] <= 1'b0;
        end
        rd_pend_reg <= pend_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.wipe)
        begin
            sent_mem[wr_addr] <= 1'b0;
        end
        else if (wr.retire && wr.emit)
        begin
            sent_mem[wr_addr] <= 1'b1;
        end
        rd_sent_reg <= sent_mem[rd_addr];
    end

    assign rd_value = rd_value_reg;
    assign rd_last  = rd_last_reg;
    assign rd_eps   = rd_eps_reg;
    assign rd_pend  = rd_pend_reg;
    assign rd_sent  = rd_sent_reg;

endmodule

### hw/rtl/dcc_deadband_cmp.sv
// ------------------------------------------------------------------------
// dcc_deadband_cmp
// Shared two-stage unit: difference, then compare against +/- epsilon.
// ------------------------------------------------------------------------
module dcc_deadband_cmp #(
    parameter int VALUE_BITS = dcc_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [VALUE_BITS-1:0]  pending,
    input  logic signed [VALUE_BITS-1:0]  last_sent,
    input  logic [dcc_pkg::EPS_W-1:0]     eps,
    output logic                          exceed
);

    localparam int DW = VALUE_BITS + 1;
    localparam int CW = (DW + 1 > dcc_pkg::EPS_W + 2) ? DW + 1 : dcc_pkg::EPS_W + 2;

    logic signed [DW-1:0] diff;
    logic signed [CW-1:0] eps_ext;
    logic signed [CW-1:0] diff_reg;
    logic signed [CW-1:0] pos_reg;
    logic signed [CW-1:0] neg_reg;

    // One extra bit keeps the difference exact.
    assign diff    = DW'(pending) - DW'(last_sent);
    assign eps_ext = CW'($signed({1'b0, eps}));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg <= CW'(diff);
            pos_reg  <= eps_ext;
            neg_reg  <= -eps_ext;
        end
    end

    assign exceed = (diff_reg > pos_reg) || (diff_reg < neg_reg);

endmodule

### verif/deadband_change_coalescer_tb.sv
// ------------------------------------------------------------------------
// deadband_change_coalescer_tb
// Self-checking bench for the deadband change coalescer. Posts park values
// in a shadow copy of the slot table; every tick scans that copy as the
// block should. The emissions that the scan predicts are queued, and each
// strobed result is checked against the oldest of them, field by field.
// ------------------------------------------------------------------------
module deadband_change_coalescer_tb;

    localparam int SLOTS       = dcc_pkg::DEF_PATH_SLOTS * dcc_pkg::DEF_CHANNELS;
    localparam int CHANS       = dcc_pkg::DEF_CHANNELS;
    localparam int VW          = dcc_pkg::IN_VALUE_W;
    localparam int EW          = dcc_pkg::EPS_W;
    localparam int FW          = dcc_pkg::FIELD_W;
    // Length of one tick scan.
    localparam int SCAN_CYCLES = 3 * SLOTS + 2;
    // Far above the slowest correct run; only a hang should reach it.
    localparam int CYCLE_LIMIT = 300000;

    logic             clk;
    logic             rst_n;
    logic             start;
    dcc_pkg::item_t   item;
    logic             busy;
    dcc_pkg::result_t result;
    logic             result_valid;

    // Shadow of the slot table.
    logic signed [VW-1:0] parked_value [SLOTS];
    logic [EW-1:0]        slot_deadband [SLOTS];
    logic signed [VW-1:0] reported_value [SLOTS];
    bit                   parked [SLOTS];
    bit                   reported_once [SLOTS];

    // Emissions predicted but not yet seen, oldest first.
    dcc_pkg::result_t due_emissions [$];

    int mismatches      = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;

    deadband_change_coalescer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    // --------------------------------------------------------------------
    // Shadow table update
    // --------------------------------------------------------------------

    // Scan every slot in index order, as a tick does. Hold each emission
    // back by one so that the final one of the run can be marked.
    task automatic flush_table();
        dcc_pkg::result_t   held;
        bit                 have_held;
        bit                 fire;
        logic signed [VW:0] change;
        logic [VW:0]        magnitude;
        have_held = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (parked[s])
            begin
                fire = !reported_once[s];
                if (!fire)
                begin
                    // One bit wider, so the difference never wraps.
                    change = {parked_value[s][VW-1], parked_value[s]}
                           - {reported_value[s][VW-1], reported_value[s]};
                    magnitude = change[VW] ? -change : change;
                    fire = magnitude > {2'b00, slot_deadband[s]};
                end
                if (fire)
                begin
                    if (have_held)
                        due_emissions.push_back(held);
                    held.out_path_slot = FW'(s / CHANS);
                    held.out_channel   = FW'(s % CHANS);
                    held.sent_value    = parked_value[s];
                    held.last_of_run   = 1'b0;
                    have_held = 1'b1;
                    reported_value[s] = parked_value[s];
                    reported_once[s]  = 1'b1;
                end
                parked[s] = 1'b0;
            end
        end
        if (have_held)
        begin
            held.last_of_run = 1'b1;
            due_emissions.push_back(held);
        end
    endtask

    task automatic apply_to_table(input dcc_pkg::item_t it);
        int s;
        if (it.command == dcc_pkg::CMD_TICK)
            flush_table();
        else
        begin
            // Every 3-bit index is in range for an 8 x 8 table.
            s = it.path_slot * CHANS + it.channel;
            parked_value[s]  = it.value;
            slot_deadband[s] = it.epsilon;
            parked[s]        = 1'b1;
        end
    endtask

    // --------------------------------------------------------------------
    // Item builders
    // --------------------------------------------------------------------

    function automatic dcc_pkg::item_t make_post(input logic [FW-1:0] path,
                                                 input logic [FW-1:0] chan,
                                                 input logic signed [VW-1:0] v,
                                                 input logic [EW-1:0] eps);
        dcc_pkg::item_t it;
        it.command   = dcc_pkg::CMD_POST;
        it.path_slot = path;
        it.channel   = chan;
        it.value     = v;
        it.epsilon   = eps;
        return it;
    endfunction

    // A tick ignores its other fields, so fill them with noise.
    function automatic dcc_pkg::item_t make_tick();
        dcc_pkg::item_t it;
        it.command   = dcc_pkg::CMD_TICK;
        it.path_slot = FW'($urandom);
        it.channel   = FW'($urandom);
        it.value     = $urandom;
        it.epsilon   = EW'($urandom);
        return it;
    endfunction

    // Pick any slot; if it has history, mostly post a value near its
    // deadband edge or its last report; otherwise post anything.
    function automatic dcc_pkg::item_t random_post();
        int                   s;
        logic [EW-1:0]        eps;
        logic signed [VW-1:0] offset;
        logic signed [VW-1:0] v;
        s = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 2))
            0:       eps = '0;
            1:       eps = EW'($urandom_range(0, 65535));
            default: eps = EW'($urandom);
        endcase
        if (reported_once[s] && $urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 4))
                0:       offset = {1'b0, eps};
                1:       offset = {1'b0, eps} + 1;
                2:       offset = -{1'b0, eps};
                3:       offset = -({1'b0, eps} + 1);
                default: offset = VW'($urandom_range(0, 64)) - 32;
            endcase
            v = reported_value[s] + offset;
        end
        else
            v = $urandom;
        return make_post(FW'(s / CHANS), FW'(s % CHANS), v, eps);
    endfunction

    // --------------------------------------------------------------------
    // Driving: start and item change on the falling edge; an item is taken
    // at the rising edge where start is high and busy is low. Each call
    // begins and ends just after a falling edge.
    // --------------------------------------------------------------------

    task automatic send_item(input dcc_pkg::item_t it);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start = 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(5, 40)) @(negedge clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start = 1'b1;
        item  = it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        apply_to_table(it);
        @(negedge clk);
    endtask

    // Drop start and hold off until every predicted emission has arrived.
    task automatic wait_drain();
        start = 1'b0;
        while (due_emissions.size() != 0)
            @(negedge clk);
    endtask

    // --------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so take every strobe.
    // --------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        dcc_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (due_emissions.size() == 0)
                report_mismatch($sformatf("unexpected result slot %0d/%0d value %h",
                                          result.out_path_slot, result.out_channel,
                                          result.sent_value));
            else
            begin
                want = due_emissions.pop_front();
                if (result.out_path_slot !== want.out_path_slot)
                    report_mismatch($sformatf("out_path_slot %0d, want %0d",
                                              result.out_path_slot, want.out_path_slot));
                if (result.out_channel !== want.out_channel)
                    report_mismatch($sformatf("out_channel %0d, want %0d",
                                              result.out_channel, want.out_channel));
                if (result.sent_value !== want.sent_value)
                    report_mismatch($sformatf("sent_value %h, want %h",
                                              result.sent_value, want.sent_value));
                if (result.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              result.last_of_run, want.last_of_run));
            end
        end
    end

    // --------------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------------

    // First sends from fresh slots: every pending slot goes out whatever
    // its deadband. Includes the corner slots, the value extremes, an
    // overwritten post and an empty tick.
    task automatic test_first_reports();
        send_item(make_post(3'd0, 3'd0, 32'sh7FFF_FFFF, '0));
        send_item(make_post(3'd7, 3'd7, 32'sh8000_0000, 31'h7FFF_FFFF));
        send_item(make_post(3'd3, 3'd5, '0, EW'($urandom)));
        send_item(make_post(3'd0, 3'd1, -32'sd1, 31'd16));
        send_item(make_post(3'd2, 3'd2, 32'sd1, 31'd3));
        // Later post to the same slot replaces the first.
        send_item(make_post(3'd2, 3'd2, 32'sd5, 31'd0));
        send_item(make_tick());
        // Nothing pending: no results, pending flags stay clear.
        send_item(make_tick());
    endtask

    // Changes exactly on, just past and far past the deadband.
    task automatic test_deadband_edges();
        // No change with zero deadband: held back.
        send_item(make_post(3'd0, 3'd0, 32'sh7FFF_FFFF, '0));
        // Full-scale swing beyond the widest deadband: sent.
        send_item(make_post(3'd7, 3'd7, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        // Change equal to the deadband: held back.
        send_item(make_post(3'd3, 3'd5, 32'sd16, 31'd16));
        // One past the deadband, downwards: sent.
        send_item(make_post(3'd0, 3'd1, -32'sd18, 31'd16));
        // Smallest step with zero deadband: sent.
        send_item(make_post(3'd2, 3'd2, 32'sd4, 31'd0));
        send_item(make_tick());
        // Widest deadband: a swing equal to it held back, a full one sent.
        send_item(make_post(3'd7, 3'd7, 32'sh0000_0000, 31'h7FFF_FFFF));
        send_item(make_post(3'd0, 3'd0, 32'sh8000_0000, 31'h7FFF_FFFF));
        send_item(make_tick());
    endtask

    // Bursts of posts closed by a tick; now and then a bare tick.
    task automatic test_random_traffic(input int budget);
        int sent;
        int burst;
        sent = 0;
        while (sent < budget)
        begin
            burst = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (burst)
            begin
                send_item(random_post());
                sent++;
            end
            send_item(make_tick());
            sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part; the sender waits out the clearing pass via busy.
        test_first_reports();
        test_deadband_edges();
        wait_drain();

        sender_idle_pct = 30;
        test_random_traffic(115);
        sender_idle_pct = 52;
        test_random_traffic(115);
        sender_idle_pct = 0;
        test_random_traffic(115);

        // Drain, then allow one full scan for any stray output.
        wait_drain();
        repeat (SCAN_CYCLES + 8) @(negedge clk);
        while (due_emissions.size() != 0)
        begin
            report_mismatch($sformatf("missing result slot %0d/%0d",
                                      due_emissions[0].out_path_slot,
                                      due_emissions[0].out_channel));
            void'(due_emissions.pop_front());
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_slot_table.sv
hw/rtl/dcc_deadband_cmp.sv
hw/rtl/deadband_change_coalescer.sv
verif/deadband_change_coalescer_tb.sv
